/* hw/rtl/bnfs_pkg.sv */
package bnfs_pkg;

    localparam int BLOCK_BYTES = 256;
    localparam int CHUNK       = 7;
    localparam int BITMAP_BITS = 37;
    localparam int ADDR_W      = $clog2(BLOCK_BYTES);
    localparam int FILL_W      = $clog2(BLOCK_BYTES + 1);
    localparam int MAX_FRAMES  = (BLOCK_BYTES + CHUNK - 1) / CHUNK;
    localparam int SEQ_W       = 6;

    // x / CHUNK as (x * DIV_MUL) >> DIV_SHIFT, exact for x up to a full block plus CHUNK.
    localparam int DIV_MUL     = 293;
    localparam int DIV_SHIFT   = 11;

    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_DATA  = 2'd1;
    localparam logic [1:0] CMD_END   = 2'd2;
    localparam logic [1:0] CMD_JUMP  = 2'd3;

    localparam logic [2:0] OP_BEGIN   = 3'd0;
    localparam logic [2:0] OP_BYTE    = 3'd1;
    localparam logic [2:0] OP_REPLY   = 3'd2;
    localparam logic [2:0] OP_TIMEOUT = 3'd3;
    localparam logic [2:0] OP_JUMP    = 3'd4;

    localparam logic [1:0] RK_ACK   = 2'd0;
    localparam logic [1:0] RK_NACK  = 2'd1;
    localparam logic [1:0] RK_ERROR = 2'd2;

    localparam logic [2:0] PH_IDLE       = 3'd0;
    localparam logic [2:0] PH_START_WAIT = 3'd1;
    localparam logic [2:0] PH_LOADING    = 3'd2;
    localparam logic [2:0] PH_BLOCK_WAIT = 3'd3;
    localparam logic [2:0] PH_END_WAIT   = 3'd4;
    localparam logic [2:0] PH_DONE       = 3'd5;
    localparam logic [2:0] PH_FAILED     = 3'd6;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [7:0]  data_byte;
        logic [1:0]  reply_kind;
        logic [36:0] reply_bitmap;
    } t_in_word;

    typedef struct packed {
        logic [3:0] frame_len;
        logic [7:0] frame_byte_0;
        logic [7:0] frame_byte_1;
        logic [7:0] frame_byte_2;
        logic [7:0] frame_byte_3;
        logic [7:0] frame_byte_4;
        logic [7:0] frame_byte_5;
        logic [7:0] frame_byte_6;
        logic [7:0] frame_byte_7;
        logic       last_in_run;
        logic [2:0] phase;
    } t_out_word;

    // Job handed from the front part to the back part.
    typedef enum logic [1:0] {
        JOB_WORD,   // start or end frame with a 32-bit word
        JOB_JUMP,   // header-only jump frame
        JOB_BLOCK   // data frames of the block, selected by mask
    } t_job_kind;

    typedef struct packed {
        t_job_kind                kind;
        logic [1:0]               cmd;
        logic [31:0]              word;
        logic [MAX_FRAMES-1:0]    mask;
        logic [FILL_W-1:0]        fill;
        logic [2:0]               phase;
    } t_job;

    // Store write from front to back.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } t_store_wr;

    function automatic logic [31:0] crc_byte(logic [31:0] c, logic [7:0] d);
        logic [31:0] x;
        x = c ^ {24'd0, d};
        for (int i = 0; i < 8; i++) begin
            x = x[0] ? ((x >> 1) ^ 32'hEDB88320) : (x >> 1);
        end
        return x;
    endfunction

endpackage

/* hw/rtl/bnfs_front.sv */
module bnfs_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  bnfs_pkg::t_in_word i_word,
    input  logic [31:0]        i_image_size,
    input  logic               i_q_ready,
    input  logic               i_back_idle,
    output logic               o_q_valid,
    output bnfs_pkg::t_job     o_job,
    output bnfs_pkg::t_store_wr o_wr
);
    import bnfs_pkg::*;

    logic [2:0]             r_phase;
    logic [FILL_W-1:0]      r_fill;
    logic [31:0]            r_acked;
    logic [31:0]            r_crc;
    logic [SEQ_W-1:0]       r_frames;

    logic [2:0]             n_phase;
    logic [FILL_W-1:0]      n_fill;
    logic [31:0]            n_acked;
    logic [31:0]            n_crc;
    logic [SEQ_W-1:0]       n_frames;

    logic                   accept;
    logic [31:0]            rem;
    logic [FILL_W:0]        fill_inc;
    logic [FILL_W+9:0]      frames_prod;
    logic [FILL_W+2:0]      frames_calc;
    logic                   ack;
    logic [MAX_FRAMES-1:0]  nack_mask;
    logic [MAX_FRAMES-1:0]  all_mask;
    t_job                   job;
    logic                   emit;

    // Hold off input while the queue cannot take a job; hold a byte until the
    // back part has finished every frame that still reads the store.
    assign o_ready = i_q_ready && ((i_word.opcode != OP_BYTE) || i_back_idle);
    assign accept  = i_valid && o_ready;
    assign rem      = i_image_size - r_acked;
    assign fill_inc = {1'b0, r_fill} + 1'b1;
    assign frames_prod = ((FILL_W + 10)'(fill_inc) + (FILL_W + 10)'(CHUNK - 1)) *
                         (FILL_W + 10)'(DIV_MUL);
    assign frames_calc = (FILL_W + 3)'(frames_prod >> DIV_SHIFT);
    assign ack = (i_word.opcode == OP_REPLY) && (i_word.reply_kind == RK_ACK);

    always_comb begin
        for (int s = 0; s < MAX_FRAMES; s++) begin
            all_mask[s]  = (s < int'(r_frames));
            nack_mask[s] = all_mask[s] &&
                           !((s < BITMAP_BITS) && i_word.reply_bitmap[s % BITMAP_BITS]);
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_fill   = r_fill;
        n_acked  = r_acked;
        n_crc    = r_crc;
        n_frames = r_frames;
        emit     = 1'b0;
        job      = '0;
        job.kind = JOB_WORD;
        o_wr     = '0;
        case (i_word.opcode)
            OP_BEGIN: begin
                n_fill   = '0;
                n_acked  = '0;
                n_crc    = '1;
                n_frames = '0;
                n_phase  = PH_START_WAIT;
                emit     = 1'b1;
                job.cmd  = CMD_START;
                job.word = i_image_size;
            end
            OP_BYTE: begin
                if (r_phase == PH_LOADING) begin
                    o_wr.en   = (r_fill < FILL_W'(BLOCK_BYTES));
                    o_wr.addr = r_fill[ADDR_W-1:0];
                    o_wr.data = i_word.data_byte;
                    n_fill    = fill_inc[FILL_W-1:0];
                    n_crc     = crc_byte(r_crc, i_word.data_byte);
                    if ({{(32-FILL_W-1){1'b0}}, fill_inc} >=
                        ((rem < 32'(BLOCK_BYTES)) ? rem : 32'(BLOCK_BYTES))) begin
                        n_frames = frames_calc[SEQ_W-1:0];
                        n_phase  = PH_BLOCK_WAIT;
                        emit     = 1'b1;
                        job.kind = JOB_BLOCK;
                        for (int s = 0; s < MAX_FRAMES; s++) begin
                            job.mask[s] = (s < int'(frames_calc));
                        end
                        job.fill = fill_inc[FILL_W-1:0];
                    end
                end
            end
            OP_REPLY, OP_TIMEOUT: begin
                case (r_phase)
                    PH_START_WAIT: begin
                        if (!ack) begin
                            n_phase = PH_FAILED;
                        end else if (i_image_size == '0) begin
                            n_phase  = PH_END_WAIT;
                            emit     = 1'b1;
                            job.cmd  = CMD_END;
                            job.word = ~r_crc;
                        end else begin
                            n_phase = PH_LOADING;
                        end
                    end
                    PH_BLOCK_WAIT: begin
                        if (i_word.opcode == OP_TIMEOUT) begin
                            if (r_frames != '0) begin
                                emit     = 1'b1;
                                job.kind = JOB_BLOCK;
                                job.fill = r_fill;
                                for (int s = 0; s < MAX_FRAMES; s++) begin
                                    job.mask[s] = (s == int'(r_frames) - 1);
                                end
                            end
                        end else if (i_word.reply_kind == RK_ACK) begin
                            n_acked  = r_acked + 32'(r_fill);
                            n_fill   = '0;
                            n_frames = '0;
                            if (n_acked >= i_image_size) begin
                                n_phase  = PH_END_WAIT;
                                emit     = 1'b1;
                                job.cmd  = CMD_END;
                                job.word = ~r_crc;
                            end else begin
                                n_phase = PH_LOADING;
                            end
                        end else if (i_word.reply_kind == RK_NACK) begin
                            emit     = (nack_mask != '0);
                            job.kind = JOB_BLOCK;
                            job.fill = r_fill;
                            job.mask = nack_mask;
                        end else if (i_word.reply_kind == RK_ERROR) begin
                            n_phase = PH_FAILED;
                        end
                    end
                    PH_END_WAIT: n_phase = ack ? PH_DONE : PH_FAILED;
                    default: ;
                endcase
            end
            OP_JUMP: begin
                if (r_phase == PH_DONE) begin
                    emit     = 1'b1;
                    job.kind = JOB_JUMP;
                    job.cmd  = CMD_JUMP;
                end
            end
            default: ;
        endcase
        job.phase = n_phase;
        if (!accept) begin
            o_wr.en = 1'b0;
        end
    end

    assign o_q_valid = accept && emit;
    assign o_job     = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_fill   <= '0;
            r_acked  <= '0;
            r_crc    <= '1;
            r_frames <= '0;
        end else if (accept) begin
            r_phase  <= n_phase;
            r_fill   <= n_fill;
            r_acked  <= n_acked;
            r_crc    <= n_crc;
            r_frames <= n_frames;
        end
    end

endmodule

/* hw/rtl/bnfs_queue.sv */
module bnfs_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  bnfs_pkg::t_job i_job,
    output logic           o_valid,
    input  logic           i_ready,
    output bnfs_pkg::t_job o_job
);
    import bnfs_pkg::*;

    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    logic push;
    logic pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

endmodule

/* hw/rtl/bnfs_back.sv */
module bnfs_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    output logic                o_q_ready,
    input  bnfs_pkg::t_job      i_job,
    input  bnfs_pkg::t_store_wr i_wr,
    output logic                o_valid,
    input  logic                i_ready,
    output bnfs_pkg::t_out_word o_word
);
    import bnfs_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EMIT
    } t_state;

    logic [7:0]              r_store [BLOCK_BYTES];
    t_state                  r_state;
    t_job                    r_job;
    logic [SEQ_W-1:0]        r_seq;
    logic [2:0]              r_byte;
    logic [7:0]              r_buf [CHUNK];
    logic [7:0]              r_rdata;
    logic                    r_rd_pend;
    logic                    r_ovalid;
    t_out_word               r_out;

    logic [ADDR_W-1:0]       raddr;
    logic [FILL_W+3:0]       off;
    logic [FILL_W+3:0]       flen_raw;
    logic [3:0]              flen;
    logic [MAX_FRAMES-1:0]   rest_mask;
    logic                    more;
    logic [SEQ_W-1:0]        next_seq;
    logic [SEQ_W-1:0]        first_seq;
    logic                    out_free;
    t_out_word               frame;

    assign o_valid   = r_ovalid;
    assign o_word    = r_out;
    assign out_free  = !r_ovalid || i_ready;
    assign o_q_ready = (r_state == S_IDLE);

    assign off = (FILL_W + 4)'(r_seq) * (FILL_W + 4)'(CHUNK);
    assign raddr = ADDR_W'(off + (FILL_W + 4)'(r_byte));
    always_comb begin
        flen_raw = '0;
        if (off < (FILL_W + 4)'(r_job.fill)) begin
            flen_raw = (FILL_W + 4)'(r_job.fill) - off;
        end
        flen = (flen_raw > (FILL_W + 4)'(CHUNK)) ? 4'(CHUNK) : flen_raw[3:0];
    end

    // Frames of the mask after the current one.
    always_comb begin
        next_seq = r_seq;
        for (int s = MAX_FRAMES - 1; s >= 0; s--) begin
            rest_mask[s] = r_job.mask[s] && (s > int'(r_seq));
            if (rest_mask[s]) next_seq = SEQ_W'(s);
        end
        more = (rest_mask != '0);
    end

    // First frame of an incoming job.
    always_comb begin
        first_seq = '0;
        for (int s = MAX_FRAMES - 1; s >= 0; s--) begin
            if (i_job.mask[s]) first_seq = SEQ_W'(s);
        end
    end

    always_comb begin
        frame       = '0;
        frame.phase = r_job.phase;
        case (r_job.kind)
            JOB_WORD: begin
                frame.frame_len    = 4'd5;
                frame.frame_byte_0 = {r_job.cmd, 6'd0};
                frame.frame_byte_1 = r_job.word[7:0];
                frame.frame_byte_2 = r_job.word[15:8];
                frame.frame_byte_3 = r_job.word[23:16];
                frame.frame_byte_4 = r_job.word[31:24];
                frame.last_in_run  = 1'b1;
            end
            JOB_JUMP: begin
                frame.frame_len    = 4'd1;
                frame.frame_byte_0 = {r_job.cmd, 6'd0};
                frame.last_in_run  = 1'b1;
            end
            default: begin
                frame.frame_len    = flen + 4'd1;
                frame.frame_byte_0 = {CMD_DATA, r_seq};
                frame.frame_byte_1 = (flen > 4'd0) ? r_buf[0] : 8'd0;
                frame.frame_byte_2 = (flen > 4'd1) ? r_buf[1] : 8'd0;
                frame.frame_byte_3 = (flen > 4'd2) ? r_buf[2] : 8'd0;
                frame.frame_byte_4 = (flen > 4'd3) ? r_buf[3] : 8'd0;
                frame.frame_byte_5 = (flen > 4'd4) ? r_buf[4] : 8'd0;
                frame.frame_byte_6 = (flen > 4'd5) ? r_buf[5] : 8'd0;
                frame.frame_byte_7 = (flen > 4'd6) ? r_buf[6] : 8'd0;
                frame.last_in_run  = !more;
            end
        endcase
    end

    // Store: write from the front, one registered read.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_store[i_wr.addr] <= i_wr.data;
        end
        r_rdata <= r_store[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ovalid  <= 1'b0;
            r_rd_pend <= 1'b0;
        end else begin
            if ((r_state == S_EMIT) && out_free) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_rd_pend <= 1'b0;
                    if (i_q_valid) begin
                        r_job  <= i_job;
                        r_seq  <= first_seq;
                        r_byte <= '0;
                        if (i_job.kind == JOB_BLOCK) begin
                            r_state <= S_READ;
                        end else begin
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_READ: begin
                    // Walk the chunk one byte a cycle through the read port.
                    if (r_rd_pend) begin
                        r_buf[r_byte - 3'd1] <= r_rdata;
                    end
                    if ({1'b0, r_byte} < flen) begin
                        r_rd_pend <= 1'b1;
                        r_byte    <= r_byte + 3'd1;
                    end else begin
                        r_rd_pend <= 1'b0;
                        r_state   <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out <= frame;
                        if ((r_job.kind == JOB_BLOCK) && more) begin
                            r_byte  <= '0;
                            r_seq   <= next_seq;
                            r_state <= S_READ;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

/* hw/rtl/block_nack_firmware_sender.sv */
// Block-acknowledged firmware sender. Write image_size, then send a begin word;
// each accepted word is classified at once by the front part, which keeps the
// phase, fill count, acked count and running CRC-32 and writes firmware bytes
// into a 256-byte block store. Frame work goes through a two-entry job queue
// to the back part, which builds the 8-byte frames: start, end and jump frames
// are built once the job has been taken, and for a data frame its up to 7
// payload bytes are first read one per cycle from the single store read port,
// and then the frame is built. A full block has 37 frames. A firmware byte
// that fills no block is taken once the back part is idle. Input stalls while
// the job queue is full, and a firmware byte also waits until the back part
// has finished all queued frame work, since the store holds only one block.
// Frames appear in order, with last_in_run marking the final frame an input
// word causes and phase giving the phase after it.
module block_nack_firmware_sender (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  bnfs_pkg::t_in_word  i_word,
    output logic                o_valid,
    input  logic                i_ready,
    output bnfs_pkg::t_out_word o_word,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [31:0]         i_cfg_data
);
    import bnfs_pkg::*;

    logic [31:0] r_image_size;
    logic        q_in_ready;
    logic        q_in_valid;
    t_job        q_in_job;
    logic        q_out_valid;
    logic        q_out_ready;
    t_job        q_out_job;
    t_store_wr   store_wr;
    logic        back_idle;

    // Take register writes at any time.
    assign o_cfg_ready = 1'b1;

    // Back part is idle with nothing queued: the store is free for new bytes.
    assign back_idle = !q_out_valid && q_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_size <= '0;
        end else if (i_cfg_valid) begin
            r_image_size <= i_cfg_data;
        end
    end

    bnfs_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_word       (i_word),
        .i_image_size (r_image_size),
        .i_q_ready    (q_in_ready),
        .i_back_idle  (back_idle),
        .o_q_valid    (q_in_valid),
        .o_job        (q_in_job),
        .o_wr         (store_wr)
    );

    bnfs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_in_valid),
        .o_ready (q_in_ready),
        .i_job   (q_in_job),
        .o_valid (q_out_valid),
        .i_ready (q_out_ready),
        .o_job   (q_out_job)
    );

    bnfs_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_out_valid),
        .o_q_ready (q_out_ready),
        .i_job     (q_out_job),
        .i_wr      (store_wr),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_word    (o_word)
    );

endmodule
